>>> hw/rtl/apr_pkg.sv
// apr_pkg: payload types, register indexes and fixed-point helpers
// used by the aliev-panfilov reaction pipeline; no dependencies
`timescale 1ns / 1ps

package apr_pkg;

  localparam int QW = 32;
  localparam int FRAC = 24;
  localparam int DIV_STEPS = 56;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MU1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MU2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPS = 3'd4;

  localparam logic signed [QW-1:0] RST_A   = 32'sd2516582;
  localparam logic signed [QW-1:0] RST_K   = 32'sd134217728;
  localparam logic signed [QW-1:0] RST_MU1 = 32'sd3355443;
  localparam logic signed [QW-1:0] RST_MU2 = 32'sd5033165;
  localparam logic signed [QW-1:0] RST_EPS = 32'sd33554;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    q_t u_val;
    q_t v_val;
    q_t stim_current;
  } apr_in_t;

  typedef struct packed {
    q_t   du_rate;
    q_t   dv_rate;
    logic range_flag;
  } apr_out_t;

  typedef struct packed {
    q_t a;
    q_t k;
    q_t mu1;
    q_t mu2;
    q_t eps;
    q_t nega1;
  } apr_cfg_t;

  typedef struct packed {
    q_t   val;
    logic sat;
  } qs_t;

  function automatic qs_t sat66(input logic signed [65:0] x);
    qs_t r;
    if (x > 66'(signed'(Q_MAX))) begin
      r.val = Q_MAX; r.sat = 1'b1;
    end else if (x < 66'(signed'(Q_MIN))) begin
      r.val = Q_MIN; r.sat = 1'b1;
    end else begin
      r.val = x[QW-1:0]; r.sat = 1'b0;
    end
    return r;
  endfunction

  // rounded product, floor after adding half an lsb
  function automatic qs_t qmul(input q_t x, input q_t y);
    logic signed [65:0] p;
    p = (66'(x) * 66'(y)) + 66'sd8388608;
    return sat66(p >>> FRAC);
  endfunction

  function automatic qs_t qadd(input q_t x, input q_t y);
    return sat66(66'(x) + 66'(y));
  endfunction

  function automatic qs_t qneg(input q_t x);
    return sat66(-66'(x));
  endfunction

endpackage

>>> hw/rtl/apr_div.sv
// apr_div: pipelined restoring divider for (v << 24) / d, truncated
// toward zero and saturated; one quotient bit per stage; uses apr_pkg
`timescale 1ns / 1ps

module apr_div import apr_pkg::*; #(
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  q_t                in_num,
  input  q_t                in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output qs_t               out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int NW = DIV_STEPS;

  logic              vld_r  [DIV_STEPS+1];
  logic [NW-1:0]     rem_r  [DIV_STEPS+1];
  logic [NW-1:0]     quo_r  [DIV_STEPS+1];
  logic [NW-1:0]     den_r  [DIV_STEPS+1];
  logic              neg_r  [DIV_STEPS+1];
  logic [SIDE_W-1:0] side_r [DIV_STEPS+1];

  logic [NW-1:0] num_mag;
  logic [NW-1:0] den_mag;

  always_comb begin
    num_mag = in_num[QW-1] ? NW'(-(57'(signed'(in_num)))) << FRAC
                           : NW'(in_num) << FRAC;
    den_mag = in_den[QW-1] ? NW'(-(33'(signed'(in_den)))) : NW'(in_den);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= in_valid;
    rem_r[0]  <= '0;
    quo_r[0]  <= num_mag;
    den_r[0]  <= den_mag;
    neg_r[0]  <= in_num[QW-1] ^ in_den[QW-1];
    side_r[0] <= in_side;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    logic [NW:0]   trial;
    logic [NW-1:0] shr;
    always_comb begin
      shr   = {rem_r[i][NW-2:0], quo_r[i][NW-1]};
      trial = {1'b0, shr} - {1'b0, den_r[i]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else vld_r[i+1] <= vld_r[i];
      rem_r[i+1]  <= trial[NW] ? shr : trial[NW-1:0];
      quo_r[i+1]  <= {quo_r[i][NW-2:0], ~trial[NW]};
      den_r[i+1]  <= den_r[i];
      neg_r[i+1]  <= neg_r[i];
      side_r[i+1] <= side_r[i];
    end
  end

  logic [NW:0] mag;
  always_comb begin
    mag = {1'b0, quo_r[DIV_STEPS]};
    out_quo = sat66(neg_r[DIV_STEPS] ? -66'(mag) : 66'(mag));
    out_valid = vld_r[DIV_STEPS];
    out_side = side_r[DIV_STEPS];
  end

endmodule

>>> hw/rtl/apr_du_path.sv
// apr_du_path: du rate pipeline, one multiply between registers,
// delayed to match the divider latency; uses apr_pkg
`timescale 1ns / 1ps

module apr_du_path import apr_pkg::*; #(
  parameter int DELAY = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  apr_in_t  in_data,
  input  apr_cfg_t cfg,
  output qs_t      out_du
);

  typedef struct packed {
    q_t u; q_t v; q_t stim;
    q_t u2; q_t t; q_t uv;
    logic sat;
  } du_st_t;

  du_st_t s1_r, s2_r, s3_r, s4_r, s5_r;
  logic   v1_r, v2_r, v3_r, v4_r, v5_r;
  qs_t    du_r [DELAY+1];
  logic   dv_r [DELAY+1];

  qs_t m_u2, m_au, m_u3, m_nu2, m_uv, a1, a2, m_k, a3, a4, ng;

  always_comb begin
    m_u2 = qmul(in_data.u_val, in_data.u_val);
    m_au = qmul(cfg.a, in_data.u_val);
    m_uv = qmul(in_data.u_val, in_data.v_val);
    m_u3 = qmul(s1_r.u, s1_r.u2);
    m_nu2 = qmul(cfg.nega1, s1_r.u2);
    a1 = qadd(s2_r.u2, s2_r.t);
    a2 = qadd(s2_r.v, a1.val);
    m_k = qmul(cfg.k, s3_r.t);
    a3 = qadd(s4_r.t, s4_r.stim);
    a4 = qadd(s4_r.uv, a3.val);
    ng = qneg(s5_r.t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
    s1_r <= '{u: in_data.u_val, v: in_data.v_val, stim: in_data.stim_current,
              u2: m_u2.val, t: m_au.val, uv: m_uv.val,
              sat: m_u2.sat | m_au.sat | m_uv.sat};
    // stage 2: u3 in v slot, (-1-a)u^2 in u2 slot
    s2_r <= '{u: s1_r.u, v: m_u3.val, stim: s1_r.stim, u2: m_nu2.val,
              t: s1_r.t, uv: s1_r.uv, sat: s1_r.sat | m_u3.sat | m_nu2.sat};
    s3_r <= '{u: s2_r.u, v: s2_r.v, stim: s2_r.stim, u2: s2_r.u2,
              t: a2.val, uv: s2_r.uv, sat: s2_r.sat | a1.sat | a2.sat};
    s4_r <= '{u: s3_r.u, v: s3_r.v, stim: s3_r.stim, u2: s3_r.u2,
              t: m_k.val, uv: s3_r.uv, sat: s3_r.sat | m_k.sat};
    s5_r <= '{u: s4_r.u, v: s4_r.v, stim: s4_r.stim, u2: s4_r.u2,
              t: a4.val, uv: s4_r.uv, sat: s4_r.sat | a3.sat | a4.sat};
    du_r[0] <= '{val: ng.val, sat: s5_r.sat | ng.sat};
    dv_r[0] <= v5_r;
  end

  for (genvar i = 0; i < DELAY; i++) begin : g_dly
    always_ff @(posedge clk) begin
      du_r[i+1] <= du_r[i];
      if (!rst_n) dv_r[i+1] <= 1'b0;
      else dv_r[i+1] <= dv_r[i];
    end
  end

  assign out_du = du_r[DELAY];

`ifndef ASSERT_OFF
  a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |=> v3_r)
    else $error("du lane valid lost");
  a_delay_valid: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |=> dv_r[0])
    else $error("du delay line valid lost");
  a_sat_prop: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && s1_r.sat) |=> s2_r.sat)
    else $error("du saturation flag dropped");
`endif

endmodule

>>> hw/rtl/aliev_panfilov_reaction_top.sv
// aliev_panfilov_reaction_top: reaction-rate pipeline for one grid point
// per cycle; uses apr_pkg, apr_du_path, apr_div
`timescale 1ns / 1ps

// channel  | ports                          | transfer when
// input    | start, busy, in_data           | start && !busy
// result   | out_strobe, out_data           | out_strobe (one cycle)
// config   | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// one point enters every cycle; busy stays low outside reset
// a point passes the denominator stage, then the bit-per-stage divider
// and then the dv product chain
// synchronous reset clears all valid bits and the config registers
// the receiver cannot stall, so no backpressure exists in the pipe

module aliev_panfilov_reaction_top import apr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  apr_in_t              in_data,
  output logic                 out_strobe,
  output apr_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  q_t                   cfg_wdata
);

  // side data carried through the divider
  typedef struct packed {
    q_t u; q_t v; logic sat; logic zero;
  } side_t;
  localparam int SW = $bits(side_t);

  q_t a_r, k_r, mu1_r, mu2_r, eps_r;
  apr_cfg_t cfg;
  qs_t na;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= RST_A; k_r <= RST_K; mu1_r <= RST_MU1; mu2_r <= RST_MU2;
      eps_r <= RST_EPS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A:   a_r <= cfg_wdata;
        REG_K:   k_r <= cfg_wdata;
        REG_MU1: mu1_r <= cfg_wdata;
        REG_MU2: mu2_r <= cfg_wdata;
        REG_EPS: eps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    na = sat66(-66'sd16777216 - 66'(a_r)); // -1.0 minus a
    cfg = '{a: a_r, k: k_r, mu1: mu1_r, mu2: mu2_r, eps: eps_r, nega1: na.val};
  end

  assign busy = !rst_n;
  logic acc;
  assign acc = start && !busy;

  // stage 0: denominator
  qs_t dd;
  logic   d_v_r;
  q_t     d_r;
  side_t  d_side_r;
  always_comb dd = qadd(mu2_r, in_data.u_val);
  always_ff @(posedge clk) begin
    if (!rst_n) d_v_r <= 1'b0;
    else d_v_r <= acc;
    d_r <= dd.val;
    d_side_r <= '{u: in_data.u_val, v: in_data.v_val,
                  sat: dd.sat | na.sat, zero: dd.val == '0};
  end

  logic          q_v;
  qs_t           q_q;
  logic [SW-1:0] q_side_raw;
  side_t         q_side;

  apr_div #(.SIDE_W(SW)) u_div (
    .clk(clk), .rst_n(rst_n), .in_valid(d_v_r), .in_num(d_side_r.v),
    .in_den(d_r), .in_side(d_side_r), .out_valid(q_v), .out_quo(q_q),
    .out_side(q_side_raw)
  );
  assign q_side = side_t'(q_side_raw);

  // dv tail: five stages
  typedef struct packed {
    q_t r; q_t s; q_t u; q_t v; logic sat; logic zero;
  } dv_st_t;
  dv_st_t e1_r, e2_r, e3_r, e4_r, e5_r;
  logic   w1_r, w2_r, w3_r, w4_r, w5_r;
  qs_t m_r, s_a, r_a, m_ks, m_us, s_b, s_n, m_f;

  always_comb begin
    m_r = qmul(mu1_r, q_q.val);
    s_a = qadd(q_side.u, cfg.nega1);
    r_a = qadd(eps_r, e1_r.r);
    m_ks = qmul(k_r, e1_r.s);
    m_us = qmul(e2_r.u, e2_r.s);
    s_b = qadd(e3_r.s, e3_r.v);
    s_n = qneg(s_b.val);
    m_f = qmul(e4_r.s, e4_r.r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_r <= 1'b0; w2_r <= 1'b0; w3_r <= 1'b0; w4_r <= 1'b0; w5_r <= 1'b0;
    end else begin
      w1_r <= q_v; w2_r <= w1_r; w3_r <= w2_r; w4_r <= w3_r; w5_r <= w4_r;
    end
    e1_r <= '{r: m_r.val, s: s_a.val, u: q_side.u, v: q_side.v,
              sat: q_side.sat | q_q.sat | m_r.sat | s_a.sat, zero: q_side.zero};
    e2_r <= '{r: r_a.val, s: m_ks.val, u: e1_r.u, v: e1_r.v,
              sat: e1_r.sat | r_a.sat | m_ks.sat, zero: e1_r.zero};
    e3_r <= '{r: e2_r.r, s: m_us.val, u: e2_r.u, v: e2_r.v,
              sat: e2_r.sat | m_us.sat, zero: e2_r.zero};
    e4_r <= '{r: e3_r.r, s: s_n.val, u: e3_r.u, v: e3_r.v,
              sat: e3_r.sat | s_b.sat | s_n.sat, zero: e3_r.zero};
    e5_r <= '{r: e4_r.r, s: m_f.val, u: e4_r.u, v: e4_r.v,
              sat: e4_r.sat | m_f.sat, zero: e4_r.zero};
  end

  // du path: 1 + 5 + DELAY matches 1 + 56 + 1 + 5 registers
  localparam int DU_DELAY = DIV_STEPS + 1;
  qs_t du;
  apr_du_path #(.DELAY(DU_DELAY)) u_du (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_data(in_data), .cfg(cfg),
    .out_du(du)
  );

  // zero denominator: dv_rate is forced to zero and range_flag is set
  always_comb begin
    out_strobe = w5_r;
    out_data.du_rate = du.val;
    out_data.dv_rate = e5_r.zero ? '0 : e5_r.s;
    out_data.range_flag = du.sat | e5_r.zero | e5_r.sat;
  end

`ifndef ASSERT_OFF
  a_no_busy: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy while running");
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && e5_r.zero) |-> (out_data.range_flag && out_data.dv_rate == '0))
    else $error("zero denominator not flagged");
  a_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    q_v |=> w1_r)
    else $error("dv tail lost an item");
`endif

endmodule
